// ===== hdl/sph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-puzzle heuristic package
// Shared widths, register codes, configuration struct and the small
// division helpers for board sides of two, three and four.
// ----------------------------------------------------------------------------
package sph_pkg;

  // Fixed field widths.
  localparam int MAX_SIDE   = 4;
  localparam int TILE_W     = 4;
  localparam int NUM_TILES  = 16;
  localparam int BOARD_W    = 64;
  localparam int EST_W      = 8;
  localparam int MODE_W     = 2;
  localparam int SIDE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Register reset values and limits.
  localparam logic [MODE_W-1:0]     MODE_RESET = '0;
  localparam logic [SIDE_W-1:0]     SIDE_MIN   = 3'd2;
  localparam logic [SIDE_W-1:0]     SIDE_RESET = 3'd3;
  localparam logic [CFG_DATA_W-1:0] GOAL_RESET = 64'hFEDC_BA98_7654_3210;
  localparam logic [EST_W-1:0]      EST_MAX    = 8'hFF;

  // Estimate selection.
  typedef enum logic [MODE_W-1:0] {
    MODE_MANHATTAN = 2'd0,
    MODE_HAMMING   = 2'd1,
    MODE_CONFLICT  = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_SIDE = 2'd1,
    CFG_GOAL = 2'd2
  } cfg_idx_e;

  // Settings seen by the lookup, scoring and output stages. The side is already clamped.
  typedef struct packed {
    mode_e             mode;
    logic [SIDE_W-1:0] side;
  } cfg_t;

  // Row of a 4-bit cell index on a board of the given side.
  // Division by three uses the reciprocal 11/32, exact for values up to 15.
  function automatic logic [2:0] side_div(input logic [TILE_W-1:0] val,
                                          input logic [SIDE_W-1:0] s);
    logic [7:0] prod;
    prod = 8'(val) * 8'd11;
    case (s)
      3'd2:    side_div = val[3:1];
      3'd3:    side_div = prod[7:5];
      default: side_div = {1'b0, val[3:2]};
    endcase
  endfunction

  // Column of a 4-bit cell index on a board of the given side.
  function automatic logic [1:0] side_mod(input logic [TILE_W-1:0] val,
                                          input logic [SIDE_W-1:0] s);
    logic [2:0] quo;
    logic [3:0] base;
    quo  = side_div(val, s);
    base = 4'(quo) * 4'd3;
    case (s)
      3'd2:    side_mod = {1'b0, val[0]};
      3'd3:    side_mod = 2'(val - base);
      default: side_mod = val[1:0];
    endcase
  endfunction

  // Absolute difference of two small unsigned values.
  function automatic logic [2:0] abs_diff(input logic [2:0] a, input logic [2:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== hdl/sliding_puzzle_heuristic_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-puzzle heuristic core
// Scores one packed board per cycle unless the output stalls, using the Manhattan,
// Hamming or Manhattan plus linear conflict distance against a configurable goal table.
//
//   Channel   Signals                              Direction  Payload
//   in        in_valid_i / in_ready_o              sink       board_i (64 bits)
//   out       out_valid_o / out_ready_i            source     estimate_o (8 bits)
//   cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i     sink       mode, side, goal table
//
// One item per cycle is accepted while the output is not stalled; each item
// passes through goal lookup, scoring, two adder levels and final select.
// Every stage carries its own valid bit and loads when it is empty or when
// the stage after it moves, so stalls on the output back up without loss.
// Reset empties the pipeline and loads the default configuration.
// The user must write configuration only while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module sliding_puzzle_heuristic_core import sph_pkg::*; #(
  parameter int MaxSide = MAX_SIDE
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [BOARD_W-1:0]    board_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [EST_W-1:0]      estimate_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int NumCells     = MaxSide * MaxSide;
  localparam int NumLines     = 2 * MaxSide;
  localparam int PairsPerLine = MaxSide * (MaxSide - 1) / 2;
  localparam int DistW        = $clog2(NumCells * 15 + 1);
  localparam int HamW         = $clog2(NumCells + 1);
  localparam int ConfW        = $clog2(NumLines * PairsPerLine + 1);
  localparam int SumW         = ((DistW > ConfW + 1) ? DistW : ConfW + 1) + 1;
  localparam int TotW         = (SumW > EST_W) ? SumW : EST_W + 1;

  // Configuration registers.
  logic [MODE_W-1:0]     mode_d, mode_q;
  logic [SIDE_W-1:0]     side_d, side_q;
  logic [CFG_DATA_W-1:0] goal_d, goal_q;
  logic [SIDE_W-1:0]     side_eff;
  cfg_t                  cfg;

  // Pipeline links.
  logic                                  lk_valid, lk_ready;
  logic [NumCells-1:0][TILE_W-1:0]       lk_goal;
  logic [NumCells-1:0]                   lk_act;
  logic                                  sc_valid, sc_ready;
  logic [NumCells-1:0][3:0]              sc_dist;
  logic [NumCells-1:0]                   sc_ham;
  logic [NumLines-1:0][PairsPerLine-1:0] sc_conf;
  logic                                  rd_valid, rd_ready;
  logic [DistW-1:0]                      rd_dist;
  logic [HamW-1:0]                       rd_ham;
  logic [ConfW-1:0]                      rd_conf;

  // Output stage.
  logic             out_valid_q;
  logic [EST_W-1:0] est_d, est_q;
  logic [TotW-1:0]  total;

  // Register writes.
  always_comb begin
    mode_d = mode_q;
    side_d = side_q;
    goal_d = goal_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE: mode_d = cfg_wdata_i[MODE_W-1:0];
        CFG_SIDE: side_d = cfg_wdata_i[SIDE_W-1:0];
        CFG_GOAL: goal_d = cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
      side_q <= SIDE_RESET;
      goal_q <= GOAL_RESET;
    end else begin
      mode_q <= mode_d;
      side_q <= side_d;
      goal_q <= goal_d;
    end
  end

  // Clamp the side into the supported range.
  always_comb begin
    if (side_q < SIDE_MIN) begin
      side_eff = SIDE_MIN;
    end else if (side_q > SIDE_W'(MaxSide)) begin
      side_eff = SIDE_W'(MaxSide);
    end else begin
      side_eff = side_q;
    end
  end

  assign cfg.mode = mode_e'(mode_q);
  assign cfg.side = side_eff;

  sph_lookup #(.MaxSide(MaxSide)) u_lookup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .goal_tbl_i (goal_q),
    .valid_i    (in_valid_i),
    .ready_o    (in_ready_o),
    .board_i    (board_i),
    .valid_o    (lk_valid),
    .ready_i    (lk_ready),
    .goal_o     (lk_goal),
    .act_o      (lk_act)
  );

  sph_score #(.MaxSide(MaxSide)) u_score (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (lk_valid),
    .ready_o (lk_ready),
    .goal_i  (lk_goal),
    .act_i   (lk_act),
    .valid_o (sc_valid),
    .ready_i (sc_ready),
    .dist_o  (sc_dist),
    .ham_o   (sc_ham),
    .conf_o  (sc_conf)
  );

  sph_reduce #(.MaxSide(MaxSide)) u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .ready_o (sc_ready),
    .dist_i  (sc_dist),
    .ham_i   (sc_ham),
    .conf_i  (sc_conf),
    .valid_o (rd_valid),
    .ready_i (rd_ready),
    .dist_o  (rd_dist),
    .ham_o   (rd_ham),
    .conf_o  (rd_conf)
  );

  // Pick the estimate; each reversed pair adds two moves.
  always_comb begin
    case (cfg.mode)
      MODE_HAMMING:  total = TotW'(rd_ham);
      MODE_CONFLICT: total = TotW'(rd_dist) + (TotW'(rd_conf) << 1);
      default:       total = TotW'(rd_dist);
    endcase
    est_d = (total > TotW'(EST_MAX)) ? EST_MAX : total[EST_W-1:0];
  end

  assign rd_ready = !out_valid_q || out_ready_i;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rd_ready) begin
      out_valid_q <= rd_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_ready && rd_valid) begin
      est_q <= est_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign estimate_o  = est_q;

endmodule

// ===== hdl/sph_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Goal lookup stage
// Unpacks the board, looks up each tile's goal cell and marks the cells
// that hold a tile on the active part of the board.
// ----------------------------------------------------------------------------
module sph_lookup import sph_pkg::*; #(
  parameter  int MaxSide  = MAX_SIDE,
  localparam int NumCells = MaxSide * MaxSide
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cfg_t                                cfg_i,
  input  logic [NUM_TILES-1:0][TILE_W-1:0]    goal_tbl_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [BOARD_W-1:0]                  board_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic [NumCells-1:0][TILE_W-1:0]     goal_o,
  output logic [NumCells-1:0]                 act_o
);

  logic                            valid_q;
  logic [NumCells-1:0][TILE_W-1:0] goal_d, goal_q;
  logic [NumCells-1:0]             act_d, act_q;
  logic [5:0]                      cells;

  // The stage takes a new item whenever it is empty or drains this cycle.
  assign ready_o = !valid_q || ready_i;
  assign cells   = 6'(cfg_i.side) * 6'(cfg_i.side);

  // Per-cell tile decode and goal lookup.
  always_comb begin
    logic [TILE_W-1:0] tile;
    tile = '0;
    for (int i = 0; i < NumCells; i++) begin
      tile      = board_i[i*TILE_W +: TILE_W];
      goal_d[i] = goal_tbl_i[tile];
      act_d[i]  = (tile != '0) && (6'(i) < cells);
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      goal_q <= goal_d;
      act_q  <= act_d;
    end
  end

  assign valid_o = valid_q;
  assign goal_o  = goal_q;
  assign act_o   = act_q;

endmodule

// ===== hdl/sph_score.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scoring stage
// Works out each tile's row plus column distance and its misplaced flag,
// and flags every reversed pair of tiles within a row or a column.
// ----------------------------------------------------------------------------
module sph_score import sph_pkg::*; #(
  parameter  int MaxSide      = MAX_SIDE,
  localparam int NumCells     = MaxSide * MaxSide,
  localparam int NumLines     = 2 * MaxSide,
  localparam int PairsPerLine = MaxSide * (MaxSide - 1) / 2,
  localparam int CellW        = $clog2(NumCells)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cfg_t                                  cfg_i,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [NumCells-1:0][TILE_W-1:0]       goal_i,
  input  logic [NumCells-1:0]                   act_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [NumCells-1:0][3:0]              dist_o,
  output logic [NumCells-1:0]                   ham_o,
  output logic [NumLines-1:0][PairsPerLine-1:0] conf_o
);

  logic                                  valid_q;
  logic [NumCells-1:0][3:0]              dist_d, dist_q;
  logic [NumCells-1:0]                   ham_d, ham_q;
  logic [NumLines-1:0][PairsPerLine-1:0] conf_d, conf_q;
  logic [NumCells-1:0][2:0]              grow;
  logic [NumCells-1:0][1:0]              gcol;

  assign ready_o = !valid_q || ready_i;

  // Goal row and column, distance and misplaced flag of each cell.
  always_comb begin
    logic [2:0] crow;
    logic [1:0] ccol;
    crow = '0;
    ccol = '0;
    for (int i = 0; i < NumCells; i++) begin
      grow[i]   = side_div(goal_i[i], cfg_i.side);
      gcol[i]   = side_mod(goal_i[i], cfg_i.side);
      crow      = side_div(4'(i), cfg_i.side);
      ccol      = side_mod(4'(i), cfg_i.side);
      dist_d[i] = act_i[i] ?
                  (4'(abs_diff(crow, grow[i])) + 4'(abs_diff({1'b0, ccol}, {1'b0, gcol[i]})))
                  : 4'd0;
      ham_d[i]  = act_i[i] && (goal_i[i] != 4'(i));
    end
  end

  // Reversed pairs. Lines 0 .. MaxSide-1 are rows, the rest are columns.
  // A tile belongs to a line when its goal lies in that same line.
  always_comb begin
    logic [4:0]                      idx;
    logic [CellW-1:0]                pos;
    logic                            on_line;
    logic [MaxSide-1:0]              mem;
    logic [MaxSide-1:0][TILE_W-1:0]  sgoal;
    int                              p;
    idx     = '0;
    pos     = '0;
    on_line = 1'b0;
    mem     = '0;
    sgoal   = '0;
    p       = 0;
    conf_d  = '0;
    for (int dir = 0; dir < 2; dir++) begin
      for (int l = 0; l < MaxSide; l++) begin
        for (int k = 0; k < MaxSide; k++) begin
          idx      = (dir == 0) ? (5'(l) * 5'(cfg_i.side) + 5'(k))
                                : (5'(k) * 5'(cfg_i.side) + 5'(l));
          on_line  = (3'(l) < cfg_i.side) && (3'(k) < cfg_i.side);
          pos      = on_line ? idx[CellW-1:0] : '0;
          sgoal[k] = goal_i[pos];
          mem[k]   = on_line && act_i[pos] &&
                     ((dir == 0) ? (grow[pos] == 3'(l)) : ({1'b0, gcol[pos]} == 3'(l)));
        end
        p = 0;
        for (int k = 0; k < MaxSide; k++) begin
          for (int j = k + 1; j < MaxSide; j++) begin
            conf_d[dir*MaxSide + l][p] = mem[k] && mem[j] && (sgoal[k] > sgoal[j]);
            p++;
          end
        end
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      dist_q <= dist_d;
      ham_q  <= ham_d;
      conf_q <= conf_d;
    end
  end

  assign valid_o = valid_q;
  assign dist_o  = dist_q;
  assign ham_o   = ham_q;
  assign conf_o  = conf_q;

endmodule

// ===== hdl/sph_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reduction stages
// Two registered adder levels: per-group partial sums and per-line conflict
// counts first, then the board totals of distance, misplaced tiles and
// reversed pairs.
// ----------------------------------------------------------------------------
module sph_reduce import sph_pkg::*; #(
  parameter  int MaxSide      = MAX_SIDE,
  localparam int NumCells     = MaxSide * MaxSide,
  localparam int NumLines     = 2 * MaxSide,
  localparam int PairsPerLine = MaxSide * (MaxSide - 1) / 2,
  localparam int PartW        = $clog2(MaxSide * 15 + 1),
  localparam int HpartW       = $clog2(MaxSide + 1),
  localparam int LineCntW     = $clog2(PairsPerLine + 1),
  localparam int DistW        = $clog2(NumCells * 15 + 1),
  localparam int HamW         = $clog2(NumCells + 1),
  localparam int ConfW        = $clog2(NumLines * PairsPerLine + 1)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  output logic                                  ready_o,
  input  logic [NumCells-1:0][3:0]              dist_i,
  input  logic [NumCells-1:0]                   ham_i,
  input  logic [NumLines-1:0][PairsPerLine-1:0] conf_i,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [DistW-1:0]                      dist_o,
  output logic [HamW-1:0]                       ham_o,
  output logic [ConfW-1:0]                      conf_o
);

  logic                              part_valid_q, tot_valid_q;
  logic                              part_ready, tot_ready;
  logic [MaxSide-1:0][PartW-1:0]     dpart_d, dpart_q;
  logic [MaxSide-1:0][HpartW-1:0]    hpart_d, hpart_q;
  logic [NumLines-1:0][LineCntW-1:0] lcnt_d, lcnt_q;
  logic [DistW-1:0]                  dist_d, dist_q;
  logic [HamW-1:0]                   ham_d, ham_q;
  logic [ConfW-1:0]                  conf_d, conf_q;

  assign tot_ready  = !tot_valid_q || ready_i;
  assign part_ready = !part_valid_q || tot_ready;
  assign ready_o    = part_ready;

  // First level: one partial per group of MaxSide cells, one count per line.
  always_comb begin
    for (int g = 0; g < MaxSide; g++) begin
      dpart_d[g] = '0;
      hpart_d[g] = '0;
      for (int c = 0; c < MaxSide; c++) begin
        dpart_d[g] = dpart_d[g] + PartW'(dist_i[g*MaxSide + c]);
        hpart_d[g] = hpart_d[g] + HpartW'(ham_i[g*MaxSide + c]);
      end
    end
    for (int ln = 0; ln < NumLines; ln++) begin
      lcnt_d[ln] = '0;
      for (int p = 0; p < PairsPerLine; p++) begin
        lcnt_d[ln] = lcnt_d[ln] + LineCntW'(conf_i[ln][p]);
      end
    end
  end

  // Second level: board totals.
  always_comb begin
    dist_d = '0;
    ham_d  = '0;
    conf_d = '0;
    for (int g = 0; g < MaxSide; g++) begin
      dist_d = dist_d + DistW'(dpart_q[g]);
      ham_d  = ham_d + HamW'(hpart_q[g]);
    end
    for (int ln = 0; ln < NumLines; ln++) begin
      conf_d = conf_d + ConfW'(lcnt_q[ln]);
    end
  end

  // Valid bits of both levels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_valid_q <= 1'b0;
      tot_valid_q  <= 1'b0;
    end else begin
      if (part_ready) begin
        part_valid_q <= valid_i;
      end
      if (tot_ready) begin
        tot_valid_q <= part_valid_q;
      end
    end
  end

  // Payload of both levels.
  always_ff @(posedge clk_i) begin
    if (part_ready && valid_i) begin
      dpart_q <= dpart_d;
      hpart_q <= hpart_d;
      lcnt_q  <= lcnt_d;
    end
    if (tot_ready && part_valid_q) begin
      dist_q <= dist_d;
      ham_q  <= ham_d;
      conf_q <= conf_d;
    end
  end

  assign valid_o = tot_valid_q;
  assign dist_o  = dist_q;
  assign ham_o   = ham_q;
  assign conf_o  = conf_q;

endmodule

// ===== hdl/sph_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-puzzle heuristic checker
// Port-level properties of the core: output handshake, back-pressure
// coupling and the fixed latency of an unstalled pipeline.
// ----------------------------------------------------------------------------
module sph_checker import sph_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [EST_W-1:0] estimate_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(estimate_o))
    else $error("estimate changed or dropped while stalled");

  // A result leaves only when it is taken.
  a_out_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result withdrawn without acceptance");

  // With the output free to move, the whole pipeline moves.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output side can drain");

  // With the output ready throughout, an accepted item reaches the output valid.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
    ##1 out_ready_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind sliding_puzzle_heuristic_core sph_checker u_sph_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding-puzzle heuristic core testbench
// Drives packed boards through the core under a sequence of mode, side and
// goal-table settings. A short table of hand-picked boards comes first,
// then well-formed and random boards. Each estimate is checked in order
// against a typed-in value or a local scoring function, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import sph_pkg::*;

  // Run shape.
  localparam int RAND_PHASES  = 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  // Codes that the package leaves unnamed: the unused mode and register index.
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  // Goal tables used by the directed rows.
  localparam logic [63:0] IDENT       = GOAL_RESET;
  localparam logic [63:0] BLANK_LAST3 = 64'hFEDC_BA97_6543_2108;
  localparam logic [63:0] ALL_ZERO    = 64'h0;
  localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] REVERSED    = 64'h0123_4567_89AB_CDEF;

  // One directed row: the settings it needs, the board, and a typed-in
  // estimate where one is obvious.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIDE_W-1:0] side;
    logic [63:0]       goals;
    logic [63:0]       board;
    logic              typed;
    logic [EST_W-1:0]  est;
  } probe_t;

  localparam int NUM_PROBES = 22;
  localparam probe_t PROBES [NUM_PROBES] = '{
    // Solved board under the reset settings.
    '{MODE_MANHATTAN, 3'd3, IDENT, IDENT, 1'b1, 8'd0},
    // Every cell holds tile 15 on the full board.
    '{MODE_MANHATTAN, 3'd4, IDENT, ALL_ONES, 1'b1, 8'd48},
    '{MODE_HAMMING, 3'd4, IDENT, ALL_ONES, 1'b1, 8'd15},
    '{MODE_CONFLICT, 3'd4, IDENT, ALL_ONES, 1'b1, 8'd48},
    // Empty and solved boards.
    '{MODE_HAMMING, 3'd4, IDENT, ALL_ZERO, 1'b1, 8'd0},
    '{MODE_CONFLICT, 3'd4, IDENT, IDENT, 1'b1, 8'd0},
    // Fully reversed board in all three scoring modes.
    '{MODE_HAMMING, 3'd4, IDENT, REVERSED, 1'b0, 8'd0},
    '{MODE_MANHATTAN, 3'd4, IDENT, REVERSED, 1'b0, 8'd0},
    '{MODE_CONFLICT, 3'd4, IDENT, REVERSED, 1'b0, 8'd0},
    // A reversed pair in a row, then in a column.
    '{MODE_CONFLICT, 3'd3, IDENT, 64'h0000_0000_0000_0012, 1'b0, 8'd0},
    '{MODE_CONFLICT, 3'd3, IDENT, 64'h0000_0000_0000_3006, 1'b0, 8'd0},
    // Every tile shares one goal cell, so no pair can be reversed.
    '{MODE_CONFLICT, 3'd4, ALL_ZERO, IDENT, 1'b0, 8'd0},
    // Goal cells that fall below the last row of a small board.
    '{MODE_CONFLICT, 3'd2, IDENT, 64'h0000_0000_0000_0C59, 1'b0, 8'd0},
    '{MODE_MANHATTAN, 3'd2, IDENT, 64'h0000_0000_0000_0C59, 1'b0, 8'd0},
    // Side values outside the legal range are clamped.
    '{MODE_MANHATTAN, 3'd0, IDENT, REVERSED, 1'b0, 8'd0},
    '{MODE_HAMMING, 3'd1, IDENT, REVERSED, 1'b0, 8'd0},
    '{MODE_CONFLICT, 3'd7, IDENT, ALL_ONES, 1'b1, 8'd48},
    '{MODE_MANHATTAN, 3'd5, IDENT, REVERSED, 1'b0, 8'd0},
    // The unused mode scores like Manhattan.
    '{MODE_SPARE, 3'd4, IDENT, ALL_ONES, 1'b1, 8'd48},
    // Cells past the used area are ignored whatever they hold.
    '{MODE_MANHATTAN, 3'd2, IDENT, 64'hFFFF_FFFF_FFFF_3210, 1'b1, 8'd0},
    // Conventional goal with the blank in the last cell, then every goal in cell 15.
    '{MODE_HAMMING, 3'd3, BLANK_LAST3, 64'h0000_0000_8765_4321, 1'b1, 8'd0},
    '{MODE_MANHATTAN, 3'd3, ALL_ONES, IDENT, 1'b0, 8'd0}
  };

  // An accepted board and the estimate it should produce.
  typedef struct packed {
    logic [63:0]      board;
    logic [EST_W-1:0] est;
  } scored_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [BOARD_W-1:0]    board_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [EST_W-1:0]      estimate_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  // Local copy of the registers as last written.
  logic [MODE_W-1:0] cur_mode  = MODE_RESET;
  logic [SIDE_W-1:0] cur_side  = SIDE_RESET;
  logic [63:0]       cur_goals = GOAL_RESET;

  scored_t expected_estimates [$];
  int      fail_count        = 0;
  int      boards_sent       = 0;
  int      estimates_checked = 0;
  int      settings_used     = 1;
  int      boards_per_mode [4] = '{0, 0, 0, 0};
  int      ready_left        = 0;

  sliding_puzzle_heuristic_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .board_i     (board_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .estimate_o  (estimate_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Side length actually used for a raw register value.
  function automatic int eff_side(input logic [SIDE_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > MAX_SIDE) return MAX_SIDE;
    return int'(raw);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Heuristic distance of a board under the current register copy.
  function automatic logic [EST_W-1:0] score_board(input logic [63:0] board);
    int s, cells, total, v, g, n, pos, dr, dc;
    int line_goals [MAX_SIDE];
    s     = eff_side(cur_side);
    cells = s * s;
    total = 0;
    if (cur_mode == MODE_HAMMING) begin
      for (int i = 0; i < cells; i++) begin
        v = int'(board[4*i +: 4]);
        g = int'(cur_goals[4*v +: 4]);
        if (v != 0 && g != i) total++;
      end
    end else begin
      for (int i = 0; i < cells; i++) begin
        v = int'(board[4*i +: 4]);
        if (v == 0) continue;
        g  = int'(cur_goals[4*v +: 4]);
        dr = i / s - g / s;
        dc = i % s - g % s;
        total += (dr < 0 ? -dr : dr) + (dc < 0 ? -dc : dc);
      end
      // Reversed pairs among tiles that belong to the line they stand in.
      if (cur_mode == MODE_CONFLICT) begin
        for (int line = 0; line < s; line++) begin
          for (int by_col = 0; by_col < 2; by_col++) begin
            n = 0;
            for (int k = 0; k < s; k++) begin
              pos = (by_col == 0) ? line * s + k : k * s + line;
              v   = int'(board[4*pos +: 4]);
              if (v == 0) continue;
              g = int'(cur_goals[4*v +: 4]);
              if (((by_col == 0) ? g / s : g % s) == line) begin
                line_goals[n] = g;
                n++;
              end
            end
            for (int a = 0; a < n; a++)
              for (int b = a + 1; b < n; b++)
                if (line_goals[a] > line_goals[b]) total += 2;
          end
        end
      end
    end
    if (total > int'(EST_MAX)) total = int'(EST_MAX);
    return EST_W'(total);
  endfunction

  // Places a random ordering of 0 .. n-1 in the low n nibbles of fill.
  function automatic logic [63:0] shuffle_cells(input int n, input logic [63:0] fill);
    logic [63:0] word;
    logic [3:0]  t;
    int          j;
    word = fill;
    for (int i = 0; i < n; i++) word[4*i +: 4] = 4'(i);
    for (int i = n - 1; i > 0; i--) begin
      j = int'($urandom_range(i, 0));
      t = word[4*i +: 4];
      word[4*i +: 4] = word[4*j +: 4];
      word[4*j +: 4] = t;
    end
    return word;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
  endtask

  // Presents one board, waits for it to be taken, then idles a random while.
  task automatic send_board(input logic [63:0] board, input bit no_gaps,
                            input bit typed, input logic [EST_W-1:0] typed_est);
    bit      took;
    int      r, gap;
    scored_t entry;
    in_valid_i <= 1'b1;
    board_i    <= board;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    entry.board = board;
    entry.est   = typed ? typed_est : score_board(board);
    expected_estimates = {expected_estimates, entry};
    boards_sent++;
    boards_per_mode[cur_mode]++;
    r = int'($urandom_range(99, 0));
    if (no_gaps || r < 45) gap = 0;
    else if (r < 85) gap = int'($urandom_range(3, 1));
    else if (r < 97) gap = int'($urandom_range(10, 4));
    else gap = int'($urandom_range(60, 20));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits until every estimate in flight has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_estimates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the write enable afterwards.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_MODE) cur_mode = data[MODE_W-1:0];
    else if (idx == CFG_SIDE) cur_side = data[SIDE_W-1:0];
    else if (idx == CFG_GOAL) cur_goals = data;
  endtask

  // Writes all registers, with junk in the unused upper bits of the small ones.
  task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [SIDE_W-1:0] side,
                              input logic [63:0] goals, input bit poke_spare);
    logic [63:0] data;
    data = rand64();
    data[MODE_W-1:0] = mode;
    write_reg(CFG_MODE, data);
    data = rand64();
    data[SIDE_W-1:0] = side;
    write_reg(CFG_SIDE, data);
    write_reg(CFG_GOAL, goals);
    // The spare index holds no register and must leave the settings alone.
    if (poke_spare) write_reg(CFG_SPARE, rand64());
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Output ready: long open stretches, short stalls and a few long ones.
  always @(posedge clk_i) begin
    int r;
    if (ready_left == 0) begin
      r = int'($urandom_range(99, 0));
      if (r < 55) begin
        out_ready_i <= 1'b1;
        ready_left = int'($urandom_range(30, 1));
      end else if (r < 90) begin
        out_ready_i <= 1'b0;
        ready_left = int'($urandom_range(3, 1));
      end else begin
        out_ready_i <= 1'b0;
        ready_left = int'($urandom_range(40, 10));
      end
    end else begin
      ready_left--;
    end
  end

  // Estimate checker, sampled mid-cycle ahead of the accepting edge.
  always @(negedge clk_i) begin
    scored_t entry;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_estimates.size() == 0) begin
        note_failure($sformatf("estimate %0d arrived with none pending", estimate_o));
      end else begin
        entry = expected_estimates.pop_front();
        estimates_checked++;
        if (estimate_o !== entry.est)
          note_failure($sformatf("estimate mismatch for board %h: expected %0d, got %0d",
                                 entry.board, entry.est, estimate_o));
      end
    end
  end

  // Main sequence.
  initial begin
    logic [MODE_W-1:0] mode;
    logic [SIDE_W-1:0] side;
    logic [63:0]       goals, board;
    int                r, s, cells;
    bit                no_gaps;
    probe_t            row;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed rows; settings change only between drained items.
    for (int p = 0; p < NUM_PROBES; p++) begin
      row = PROBES[p];
      if (row.mode != cur_mode || row.side != cur_side || row.goals != cur_goals) begin
        settle();
        apply_config(row.mode, row.side, row.goals, 1'b0);
      end
      send_board(row.board, 1'b0, row.typed, row.est);
    end

    // Random phases, each under fresh settings.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r = int'($urandom_range(9, 0));
      if (r < 3) mode = MODE_MANHATTAN;
      else if (r < 6) mode = MODE_HAMMING;
      else if (r < 9) mode = MODE_CONFLICT;
      else mode = MODE_SPARE;
      // Force both side extremes early, then mostly legal sides.
      if (ph == 0) side = 3'd2;
      else if (ph == 1) side = 3'd4;
      else begin
        r = int'($urandom_range(9, 0));
        side = (r < 8) ? SIDE_W'(2 + r % 3) : SIDE_W'($urandom_range(7, 0));
      end
      s     = eff_side(side);
      cells = s * s;
      r     = int'($urandom_range(5, 0));
      case (r)
        0: goals = IDENT;
        1: begin
          // Tiles 1 .. cells-1 in order with the blank last.
          goals = rand64();
          for (int v = 1; v < cells; v++) goals[4*v +: 4] = 4'(v - 1);
          goals[3:0] = 4'(cells - 1);
        end
        2, 3: goals = shuffle_cells(16, 64'h0);
        4: goals = rand64();
        default: goals = shuffle_cells(cells, rand64());
      endcase
      settle();
      apply_config(mode, side, goals, (ph % 4) == 0);
      no_gaps = (ph % 4) == 3;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = int'($urandom_range(9, 0));
        if (r < 7) board = shuffle_cells(cells, rand64());
        else if (r < 8) board = shuffle_cells(16, 64'h0);
        else board = rand64();
        send_board(board, no_gaps, 1'b0, '0);
      end
    end

    settle();
    if (expected_estimates.size() != 0)
      note_failure($sformatf("%0d estimates never arrived", expected_estimates.size()));
    $display("Scored %0d boards under %0d register settings; %0d estimates compared.",
             boards_sent, settings_used, estimates_checked);
    $display("Boards per mode: manhattan %0d, hamming %0d, conflict %0d, spare %0d.",
             boards_per_mode[0], boards_per_mode[1], boards_per_mode[2], boards_per_mode[3]);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Timed out with %0d estimates pending.", expected_estimates.size());
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
